// ----- design/mbq_pkg.sv -----
// ----------------------------------------------------------------------------
// mbq_pkg
// Shared types and constants for the multichannel biquad filter.
// ----------------------------------------------------------------------------
package mbq_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int COEF_W    = 20;
  localparam int FRAC_W    = 16;
  localparam int NUM_COEF  = 5;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = 48;
  localparam int SEL_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FF0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FF1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FF2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FB1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FB2 = 3'd4;

  // operand selects for the shared multiplier, one per tap
  localparam logic [SEL_W-1:0] SEL_X  = 3'd0;
  localparam logic [SEL_W-1:0] SEL_X1 = 3'd1;
  localparam logic [SEL_W-1:0] SEL_X2 = 3'd2;
  localparam logic [SEL_W-1:0] SEL_Y1 = 3'd3;
  localparam logic [SEL_W-1:0] SEL_Y2 = 3'd4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_bank_t;

  localparam coef_bank_t COEF_RESET = {20'h00000, 20'h00000, 20'h00000, 20'h00000, 20'h10000};

  localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam sample_t SAMPLE_MIN = 24'sh800000;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = 48'sd32768;

  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } taps_t;

  typedef struct packed {
    logic             load;
    logic             mul_en;
    logic             acc_en;
    logic [SEL_W-1:0] sel;
  } mac_ctl_t;

endpackage

// ----- design/mbq_state_mem.sv -----
// ----------------------------------------------------------------------------
// mbq_state_mem
// Per-channel delay line store, one entry per channel, registered read.
// An entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module mbq_state_mem #(
  parameter int CHANNELS = 2,
  parameter int ADDR_W   = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output mbq_pkg::taps_t    rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  mbq_pkg::taps_t    wr_data
);
  import mbq_pkg::*;

  taps_t               mem [CHANNELS];
  logic [CHANNELS-1:0] written;
  taps_t               rd_q;
  logic                rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

// ----- design/mbq_mac.sv -----
// ----------------------------------------------------------------------------
// mbq_mac
// Shared multiply-accumulate over the five taps, then round and saturate.
// ----------------------------------------------------------------------------
module mbq_mac (
  input  logic                clk,
  input  mbq_pkg::mac_ctl_t   ctl,
  input  mbq_pkg::coef_bank_t coefs,
  input  mbq_pkg::sample_t    x_in,
  input  mbq_pkg::taps_t      taps_in,
  output mbq_pkg::taps_t      taps,
  output mbq_pkg::sample_t    x_cur,
  output mbq_pkg::sample_t    y
);
  import mbq_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  sample_t                  op;
  coef_t                    c;
  logic [ACC_W-SAMPLE_W-FRAC_W:0] hi;

  always_comb begin
    case (ctl.sel)
      SEL_X: begin
        op = x_cur;
        c  = coefs[0];
      end
      SEL_X1: begin
        op = taps.x1;
        c  = coefs[1];
      end
      SEL_X2: begin
        op = taps.x2;
        c  = coefs[2];
      end
      SEL_Y1: begin
        op = taps.y1;
        c  = coefs[3];
      end
      SEL_Y2: begin
        op = taps.y2;
        c  = coefs[4];
      end
      default: begin
        op = '0;
        c  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_cur <= x_in;
      taps  <= taps_in;
    end
    if (ctl.mul_en) begin
      prod <= c * op;
    end
    if (ctl.load) begin
      acc <= ROUND_BIAS;
    end else if (ctl.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // floor by 2^16, then clamp to 24 bits
  assign hi = acc[ACC_W-1:SAMPLE_W+FRAC_W-1];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      y = acc[SAMPLE_W+FRAC_W-1:FRAC_W];
    end else if (acc[ACC_W-1]) begin
      y = SAMPLE_MIN;
    end else begin
      y = SAMPLE_MAX;
    end
  end

endmodule

// ----- design/multichannel_biquad_filter.sv -----
// ----------------------------------------------------------------------------
// multichannel_biquad_filter
// Direct form I biquad with per-channel delay state held in a small memory.
// An accepted item waits in an input register, then passes through the load
// state, the MAC steps of the single shared multiplier over five taps and the
// done state. One item is filtered at a time, with state read and write-back.
// Reset: synchronous; coefficients return to pass-through, delay state reads zero.
// ----------------------------------------------------------------------------
module multichannel_biquad_filter #(
  parameter int CHANNELS = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [mbq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbq_pkg::COEF_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             channel_index,
  input  mbq_pkg::sample_t                 in_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mbq_pkg::sample_t                 out_sample
);
  import mbq_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  coef_bank_t       coefs;
  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [SEL_W-1:0] step;
  logic             in_full;
  logic [CH_W-1:0]  in_ch;
  sample_t          in_x;
  logic [CH_W-1:0]  work_ch;
  sample_t          work_x;
  logic             take;
  logic             accept;
  logic             finish;
  mac_ctl_t         ctl;
  taps_t            rd_taps;
  taps_t            taps;
  taps_t            wr_taps;
  sample_t          x_cur;
  sample_t          y;

  always_ff @(posedge clk) begin
    if (rst) begin
      coefs <= COEF_RESET;
    end else if (cfg_write && (cfg_index <= REG_FB2)) begin
      coefs[cfg_index] <= cfg_data;
    end
  end

  assign take     = in_full && (state == S_IDLE);
  assign in_stall = in_full && !take;
  assign accept   = in_valid && !in_stall;
  assign finish   = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_ch <= (CHANNELS > 1) ? CH_W'(channel_index) : '0;
      in_x  <= in_sample;
    end
    if (take) begin
      work_ch <= in_ch;
      work_x  <= in_x;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        state_next = S_MAC;
      end
      S_MAC: begin
        if (step == SEL_W'(NUM_COEF)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == S_MAC) begin
        step <= step + SEL_W'(1);
      end else begin
        step <= '0;
      end
    end
  end

  always_comb begin
    ctl.load   = (state == S_LOAD);
    ctl.mul_en = (state == S_MAC) && (step < SEL_W'(NUM_COEF));
    ctl.acc_en = (state == S_MAC) && (step != '0);
    ctl.sel    = step;
  end

  assign wr_taps = '{x1: x_cur, x2: taps.x1, y1: y, y2: taps.y1};

  mbq_state_mem #(
    .CHANNELS (CHANNELS),
    .ADDR_W   (CH_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (take),
    .rd_addr (in_ch),
    .rd_data (rd_taps),
    .wr_en   (finish),
    .wr_addr (work_ch),
    .wr_data (wr_taps)
  );

  mbq_mac u_mac (
    .clk     (clk),
    .ctl     (ctl),
    .coefs   (coefs),
    .x_in    (work_x),
    .taps_in (rd_taps),
    .taps    (taps),
    .x_cur   (x_cur),
    .y       (y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_sample <= y;
    end
  end

endmodule

// ----- design/mbq_checker.sv -----
// ----------------------------------------------------------------------------
// mbq_checker
// Port-level checks for the multichannel biquad filter.
// ----------------------------------------------------------------------------
module mbq_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input mbq_pkg::sample_t out_sample
);
  import mbq_pkg::*;

  // reset leaves both sides empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  // held result does not move while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_sample))
    else $error("stalled output changed");

  // input side only fills up right after accepting an item
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall without an accepted item");

  // a result never appears in the cycle right after reset
  a_no_early_out: assert property (@(posedge clk)
    $rose(out_valid) |-> !$past(rst))
    else $error("output right after reset");

endmodule

bind multichannel_biquad_filter mbq_checker u_mbq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_sample (out_sample)
);
